// ----- src/lph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

    localparam int SLOT_BITS  = 12;
    localparam int MAX_SLOTS  = 1 << SLOT_BITS;
    localparam int COUNT_W    = SLOT_BITS + 1;
    localparam int SIZE_W     = 4;
    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 48;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SLOT_BITS);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic                 func;
        logic [KEY_W-1:0]     key_low;
        logic [KEY_W-1:0]     key_high;
        logic [VALUE_W-1:0]   value_in;
        logic [SLOT_BITS-1:0] home;
    } lph_op_t;

    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key_low;
        logic [KEY_W-1:0]   key_high;
        logic [VALUE_W-1:0] value;
    } lph_slot_t;

endpackage
`default_nettype wire

// ----- src/lph_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lph_front
    import lph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic [SLOT_BITS-1:0]  mask,
    input  wire logic                  clearing,
    output logic                       q_valid,
    output lph_op_t                    q_op,
    input  wire logic                  q_pop
);

    lph_op_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    lph_op_t    op_in;

    assign s_tready = (count_reg != 2'd2) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        op_in.func     = s_tuser;
        op_in.key_low  = s_tdata[63:0];
        op_in.key_high = s_tdata[127:64];
        op_in.value_in = s_tdata[159:128];
        // The home slot is the low key bits cut down to the active table size.
        op_in.home     = s_tdata[SLOT_BITS-1:0] & mask;
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next     = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/lph_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lph_back
    import lph_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [SIZE_W-1:0]      cfg_data,
    output logic [SLOT_BITS-1:0]        mask,
    output logic                        clearing,
    input  wire logic                   q_valid,
    input  wire lph_op_t                q_op,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    lph_slot_t mem [MAX_SLOTS];
    lph_slot_t rd_data_reg;

    logic [1:0]            state_reg, state_next;
    logic [SIZE_W-1:0]     size_reg;
    logic [SLOT_BITS-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic [SLOT_BITS-1:0]  probes_reg, probes_next;
    logic [COUNT_W-1:0]    used_reg, used_next;
    lph_op_t               op_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    lph_slot_t             wr_data;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic [SLOT_BITS-1:0]  step_idx;
    logic [SIZE_W-1:0]     size_eff;
    logic                  hit;
    logic [STATUS_W-1:0]   res_status;
    logic [VALUE_W-1:0]    res_value;

    // Sizes above the memory depth are held at the largest table.
    assign size_eff = (size_reg > SIZE_W'(SLOT_BITS)) ? SIZE_W'(SLOT_BITS) : size_reg;
    assign mask     = SLOT_BITS'(({{SLOT_BITS{1'b0}}, 1'b1} << size_eff) - 1'b1);
    assign clearing = (state_reg == S_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign step_idx = (idx_reg + 1'b1) & mask;
    assign hit      = rd_data_reg.used && (rd_data_reg.key_low == op_reg.key_low)
                      && (rd_data_reg.key_high == op_reg.key_high);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        probes_next    = probes_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = clr_cnt_reg;
        wr_data        = '0;
        rd_addr        = q_op.home;
        res_status     = ST_NOT_FOUND;
        res_value      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_BITS'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // Start only when the result register will be free.
                if (q_valid && (!out_valid_reg || m_tready))
                begin
                    q_pop       = 1'b1;
                    idx_next    = q_op.home;
                    probes_next = '0;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                rd_addr = step_idx;
                if (!rd_data_reg.used || hit || (probes_reg == mask))
                begin
                    if (!rd_data_reg.used)
                    begin
                        if (op_reg.func == FUNC_INSERT)
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = idx_reg;
                            wr_data.used     = 1'b1;
                            wr_data.key_low  = op_reg.key_low;
                            wr_data.key_high = op_reg.key_high;
                            wr_data.value    = op_reg.value_in;
                            used_next        = used_reg + 1'b1;
                            res_status       = ST_INSERTED;
                        end
                    end
                    else if (hit)
                    begin
                        if (op_reg.func == FUNC_INSERT)
                        begin
                            res_status = ST_DUPLICATE;
                        end
                        else
                        begin
                            res_status = ST_FOUND;
                            res_value  = rd_data_reg.value;
                        end
                    end
                    else if (op_reg.func == FUNC_INSERT)
                    begin
                        res_status = ST_FULL;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {used_next, res_value, res_status};
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next    = step_idx;
                    probes_next = probes_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (cfg_valid)
        begin
            state_next   = S_CLEAR;
            clr_cnt_next = '0;
            used_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        idx_reg      <= idx_next;
        probes_reg   <= probes_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            used_reg      <= '0;
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/linear_probe_hash_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tdata key_low, key_high, value_in; tuser func
// m_*       out        m_tvalid/m_tready   tdata status, value_out, entry_count
// cfg_*     in         cfg_valid/cfg_ready cfg_data size_log2
//
// An operation leaves the queue from the idle state, then probes one slot at a time
// through the single read port of the slot memory. After reset and after every size
// write, the whole slot memory is cleared, all 4096 slots, during which s_tready is
// low. A two-word queue lets the input side run on while the prober works, and the
// result register holds a word until taken.
module linear_probe_hash_table_unit
    import lph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // key_low, key_high, value_in
    input  wire logic                  s_tuser,   // func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // status, value_out, entry_count
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [SIZE_W-1:0]     cfg_data
);

    logic [SLOT_BITS-1:0] mask;
    logic                 clearing;
    logic                 q_valid;
    logic                 q_pop;
    lph_op_t              q_op;

    assign cfg_ready = 1'b1;

    lph_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .mask     (mask),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop)
    );

    lph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .mask      (mask),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ----- src/lph_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lph_checker
    import lph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_FULL)
        else $error("status code out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_FOUND) |-> m_tdata[34:3] == '0)
        else $error("value_out set on a result that is not found");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:35] <= COUNT_W'(MAX_SLOTS))
        else $error("entry_count above table capacity");

endmodule

bind linear_probe_hash_table_unit lph_checker u_lph_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
